@@ design/assert_macros.svh @@
// Assertion macros shared by the voxel mesher RTL.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VFCM_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VFCM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/vfcm_pkg.sv @@
// Package for the voxel face-culling mesher: codes, control word layout,
// status bundle and the microcode table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vfcm_pkg;

  localparam int EDGE_LOG2_DEF = 4;

  // Tile split: row = (type * 205) >> 11 is exact for 8-bit types.
  localparam int TILE_DIV   = 10;
  localparam int TILE_RECIP = 205;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_MESH  = 2'd1;
  localparam logic [1:0] KIND_BEGIN = 2'd2;

  localparam logic [1:0] REG_CHUNK_X = 2'd0;
  localparam logic [1:0] REG_CHUNK_Y = 2'd1;
  localparam logic [1:0] REG_CHUNK_Z = 2'd2;

  localparam logic [2:0] DIR_NZ = 3'd0;
  localparam logic [2:0] DIR_PZ = 3'd1;
  localparam logic [2:0] DIR_NX = 3'd2;
  localparam logic [2:0] DIR_PX = 3'd3;
  localparam logic [2:0] DIR_PY = 3'd4;
  localparam logic [2:0] DIR_NY = 3'd5;

  // Datapath actions
  localparam logic [2:0] OP_NOP       = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_ACCEPT    = 3'd2;
  localparam logic [2:0] OP_WR_CMP    = 3'd3;
  localparam logic [2:0] OP_LOAD_TYPE = 3'd4;
  localparam logic [2:0] OP_STATUS    = 3'd5;
  localparam logic [2:0] OP_EMIT      = 3'd6;

  // Sequencing conditions
  localparam logic [2:0] SQ_NEXT       = 3'd0;
  localparam logic [2:0] SQ_JUMP       = 3'd1;
  localparam logic [2:0] SQ_DISPATCH   = 3'd2;
  localparam logic [2:0] SQ_ZERO_EXIT  = 3'd3;
  localparam logic [2:0] SQ_WAIT_OUT   = 3'd4;
  localparam logic [2:0] SQ_EMIT_LOOP  = 3'd5;
  localparam logic [2:0] SQ_CLEAR_LOOP = 3'd6;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] S_CLEAR  = 4'd0;
  localparam logic [STEP_W-1:0] S_IDLE   = 4'd1;
  localparam logic [STEP_W-1:0] S_WR_RD  = 4'd2;
  localparam logic [STEP_W-1:0] S_WR_CMP = 4'd3;
  localparam logic [STEP_W-1:0] S_BEGIN  = 4'd4;
  localparam logic [STEP_W-1:0] S_M_C    = 4'd5;
  localparam logic [STEP_W-1:0] S_M_T    = 4'd6;
  localparam logic [STEP_W-1:0] S_M_N1   = 4'd7;
  localparam logic [STEP_W-1:0] S_M_N2   = 4'd8;
  localparam logic [STEP_W-1:0] S_M_N3   = 4'd9;
  localparam logic [STEP_W-1:0] S_M_N4   = 4'd10;
  localparam logic [STEP_W-1:0] S_M_N5   = 4'd11;
  localparam logic [STEP_W-1:0] S_M_LAST = 4'd12;
  localparam logic [STEP_W-1:0] S_EMIT   = 4'd13;

  typedef struct packed {
    logic [2:0]        op;
    logic              rd_nbr;
    logic [2:0]        rd_dir;
    logic              cap_en;
    logic [2:0]        cap_dir;
    logic [2:0]        seq;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic type_zero;
    logic out_free;
    logic mask_empty;
    logic mask_last;
    logic clr_done;
  } status_t;

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w        = '0;
    w.op     = OP_NOP;
    w.seq    = SQ_NEXT;
    w.target = S_IDLE;
    unique case (step)
      S_CLEAR: begin
        w.op  = OP_CLEAR;
        w.seq = SQ_CLEAR_LOOP;
      end
      S_IDLE: begin
        w.op  = OP_ACCEPT;
        w.seq = SQ_DISPATCH;
      end
      S_WR_RD: w.seq = SQ_NEXT;
      S_WR_CMP: begin
        w.op  = OP_WR_CMP;
        w.seq = SQ_JUMP;
      end
      S_BEGIN: begin
        w.op  = OP_STATUS;
        w.seq = SQ_WAIT_OUT;
      end
      S_M_C: w.seq = SQ_NEXT;
      S_M_T: begin
        w.op     = OP_LOAD_TYPE;
        w.rd_nbr = 1'b1;
        w.rd_dir = DIR_NZ;
        w.seq    = SQ_ZERO_EXIT;
      end
      S_M_N1: begin
        w.rd_nbr  = 1'b1;
        w.rd_dir  = DIR_PZ;
        w.cap_en  = 1'b1;
        w.cap_dir = DIR_NZ;
      end
      S_M_N2: begin
        w.rd_nbr  = 1'b1;
        w.rd_dir  = DIR_NX;
        w.cap_en  = 1'b1;
        w.cap_dir = DIR_PZ;
      end
      S_M_N3: begin
        w.rd_nbr  = 1'b1;
        w.rd_dir  = DIR_PX;
        w.cap_en  = 1'b1;
        w.cap_dir = DIR_NX;
      end
      S_M_N4: begin
        w.rd_nbr  = 1'b1;
        w.rd_dir  = DIR_PY;
        w.cap_en  = 1'b1;
        w.cap_dir = DIR_PX;
      end
      S_M_N5: begin
        w.rd_nbr  = 1'b1;
        w.rd_dir  = DIR_NY;
        w.cap_en  = 1'b1;
        w.cap_dir = DIR_PY;
      end
      S_M_LAST: begin
        w.cap_en  = 1'b1;
        w.cap_dir = DIR_NY;
      end
      S_EMIT: begin
        w.op  = OP_EMIT;
        w.seq = SQ_EMIT_LOOP;
      end
      default: w.seq = SQ_JUMP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/voxel_face_culling_mesher_unit.sv @@
// Top level of the voxel face-culling mesher: sequencer plus datapath.
// Depends on vfcm_pkg, vfcm_seq, vfcm_dp (and vfcm_ram), assert_macros.svh.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    kind, vox_x, vox_y, vox_z, new_type
//   out      out_valid / out_ready  record_kind .. last (one record per transfer)
//   cfg      cfg_write              cfg_index, cfg_data (no back-pressure)
//
// After reset the voxel RAM is cleared one entry a cycle, all 2**(3*EDGE_LOG2)
// entries (4096 by default); in_ready stays low meanwhile, cfg writes are taken.
// Write item: accept, read, compare and conditional write on the one RAM port.
// Begin-pass item: accept, then the status record. Mesh item: an empty voxel ends
// after the centre read, else seven serial reads of the single-port voxel RAM
// (centre and six neighbours), a last capture, and one face record per open side;
// a stalled out channel holds the step.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module voxel_face_culling_mesher_unit #(
  parameter int EDGE_LOG2 = vfcm_pkg::EDGE_LOG2_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic [3:0]         vox_x,
  input  wire logic [3:0]         vox_y,
  input  wire logic [3:0]         vox_z,
  input  wire logic [7:0]         new_type,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [11:0]        cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    record_kind,
  output logic [2:0]              face_dir,
  output logic signed [16:0]      corner_x,
  output logic signed [16:0]      corner_y,
  output logic signed [16:0]      corner_z,
  output logic                    invert,
  output logic [3:0]              tile_col,
  output logic [4:0]              tile_row,
  output logic [16:0]             vertex_base,
  output logic                    was_dirty,
  output logic                    last
);

  vfcm_pkg::ctrl_word_t        ctrl;
  vfcm_pkg::status_t           stat;
  logic [vfcm_pkg::STEP_W-1:0] step;
  logic                        in_fire;

  assign in_ready = (ctrl.op == vfcm_pkg::OP_ACCEPT);
  assign in_fire  = in_valid && in_ready;

  vfcm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .in_fire(in_fire),
    .kind   (kind),
    .stat   (stat),
    .step   (step),
    .ctrl   (ctrl)
  );

  vfcm_dp #(
    .EDGE_LOG2(EDGE_LOG2)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_fire    (in_fire),
    .vox_x      (vox_x),
    .vox_y      (vox_y),
    .vox_z      (vox_z),
    .new_type   (new_type),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (out_ready),
    .stat       (stat),
    .out_valid  (out_valid),
    .record_kind(record_kind),
    .face_dir   (face_dir),
    .corner_x   (corner_x),
    .corner_y   (corner_y),
    .corner_z   (corner_z),
    .invert     (invert),
    .tile_col   (tile_col),
    .tile_row   (tile_row),
    .vertex_base(vertex_base),
    .was_dirty  (was_dirty),
    .last       (last)
  );

  `VFCM_ASSERT_NOW(a_ready_only_idle, clk, rst, in_ready,
                   step == vfcm_pkg::S_IDLE, "in_ready outside idle step")
  `VFCM_ASSERT_NEXT(a_mesh_dispatch, clk, rst, in_fire && (kind == vfcm_pkg::KIND_MESH),
                    step == vfcm_pkg::S_M_C, "mesh item not dispatched")
  `VFCM_ASSERT_NEXT(a_last_face_exit, clk, rst,
                    (ctrl.op == vfcm_pkg::OP_EMIT) && stat.out_free && !stat.mask_empty &&
                    stat.mask_last,
                    (step == vfcm_pkg::S_IDLE) && out_valid && last,
                    "final face did not end the item")
  `VFCM_ASSERT_NEXT(a_status_record, clk, rst, (ctrl.op == vfcm_pkg::OP_STATUS) && stat.out_free,
                    out_valid && record_kind && last && (vertex_base == 17'd0),
                    "bad pass status record")

endmodule

`default_nettype wire

@@ design/vfcm_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vfcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ design/vfcm_seq.sv @@
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on vfcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfcm_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_fire,
  input  wire logic [1:0]                   kind,
  input  wire vfcm_pkg::status_t            stat,
  output logic      [vfcm_pkg::STEP_W-1:0]  step,
  output vfcm_pkg::ctrl_word_t              ctrl
);

  logic [vfcm_pkg::STEP_W-1:0] step_next;
  logic [vfcm_pkg::STEP_W-1:0] step_inc;

  assign ctrl     = vfcm_pkg::ucode(step);
  assign step_inc = step + vfcm_pkg::STEP_W'(1);

  always_comb begin
    step_next = step;
    unique case (ctrl.seq)
      vfcm_pkg::SQ_NEXT: step_next = step_inc;
      vfcm_pkg::SQ_JUMP: step_next = ctrl.target;
      vfcm_pkg::SQ_DISPATCH: begin
        if (in_fire) begin
          case (kind)
            vfcm_pkg::KIND_WRITE: step_next = vfcm_pkg::S_WR_RD;
            vfcm_pkg::KIND_MESH:  step_next = vfcm_pkg::S_M_C;
            vfcm_pkg::KIND_BEGIN: step_next = vfcm_pkg::S_BEGIN;
            default:              step_next = vfcm_pkg::S_IDLE;
          endcase
        end
      end
      vfcm_pkg::SQ_ZERO_EXIT: step_next = stat.type_zero ? ctrl.target : step_inc;
      vfcm_pkg::SQ_WAIT_OUT: begin
        if (stat.out_free) begin
          step_next = ctrl.target;
        end
      end
      vfcm_pkg::SQ_EMIT_LOOP: begin
        // leave once the final open side has gone into the output register, or when no side is open
        if (stat.mask_empty || (stat.out_free && stat.mask_last)) begin
          step_next = ctrl.target;
        end
      end
      vfcm_pkg::SQ_CLEAR_LOOP: begin
        if (stat.clr_done) begin
          step_next = ctrl.target;
        end
      end
      default: step_next = vfcm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= vfcm_pkg::S_CLEAR;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

@@ design/vfcm_dp.sv @@
// Mesher datapath: item registers, voxel RAM, side mask, counters and the
// output register. Depends on vfcm_pkg and vfcm_ram.
`timescale 1ns / 1ps
`default_nettype none

module vfcm_dp #(
  parameter int EDGE_LOG2 = vfcm_pkg::EDGE_LOG2_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire vfcm_pkg::ctrl_word_t ctrl,
  input  wire logic                 in_fire,
  input  wire logic [3:0]           vox_x,
  input  wire logic [3:0]           vox_y,
  input  wire logic [3:0]           vox_z,
  input  wire logic [7:0]           new_type,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [11:0]          cfg_data,
  input  wire logic                 out_ready,
  output vfcm_pkg::status_t         stat,
  output logic                      out_valid,
  output logic                      record_kind,
  output logic [2:0]                face_dir,
  output logic signed [16:0]        corner_x,
  output logic signed [16:0]        corner_y,
  output logic signed [16:0]        corner_z,
  output logic                      invert,
  output logic [3:0]                tile_col,
  output logic [4:0]                tile_row,
  output logic [16:0]               vertex_base,
  output logic                      was_dirty,
  output logic                      last
);

  localparam int CW = EDGE_LOG2;
  localparam int AW = 3 * EDGE_LOG2;

  logic [CW-1:0]  x_r, y_r, z_r;
  logic [7:0]     nt_r;
  logic [7:0]     type_r;
  logic [4:0]     row_r;
  logic [5:0]     mask;
  logic [16:0]    vcount;
  logic           dirty;
  logic [11:0]    chunk_x, chunk_y, chunk_z;
  logic [AW-1:0]  clr_addr;

  logic [AW-1:0]  ram_addr;
  logic           ram_we;
  logic [7:0]     ram_wdata;
  logic [7:0]     rdata;
  logic [AW-1:0]  nbr_addr;
  logic           edge_hit;

  logic           out_free;
  logic           emit_fire;
  logic           status_fire;
  logic [2:0]     sel;
  logic [5:0]     mask_rest;
  logic [15:0]    row_prod;
  logic [7:0]     col_full;
  logic [CW:0]    lx, ly, lz;
  logic [16:0]    wx, wy, wz;

  vfcm_ram #(
    .WIDTH(8),
    .DEPTH(2 ** AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(rdata)
  );

  // Neighbour address; wraps at the chunk edge, where the data is ignored.
  always_comb begin
    unique case (ctrl.rd_dir)
      vfcm_pkg::DIR_NZ: nbr_addr = {y_r, z_r - CW'(1), x_r};
      vfcm_pkg::DIR_PZ: nbr_addr = {y_r, z_r + CW'(1), x_r};
      vfcm_pkg::DIR_NX: nbr_addr = {y_r, z_r, x_r - CW'(1)};
      vfcm_pkg::DIR_PX: nbr_addr = {y_r, z_r, x_r + CW'(1)};
      vfcm_pkg::DIR_PY: nbr_addr = {y_r + CW'(1), z_r, x_r};
      vfcm_pkg::DIR_NY: nbr_addr = {y_r - CW'(1), z_r, x_r};
      default:          nbr_addr = {y_r, z_r, x_r};
    endcase
  end

  always_comb begin
    unique case (ctrl.cap_dir)
      vfcm_pkg::DIR_NZ: edge_hit = (z_r == '0);
      vfcm_pkg::DIR_PZ: edge_hit = (z_r == '1);
      vfcm_pkg::DIR_NX: edge_hit = (x_r == '0);
      vfcm_pkg::DIR_PX: edge_hit = (x_r == '1);
      vfcm_pkg::DIR_PY: edge_hit = (y_r == '1);
      vfcm_pkg::DIR_NY: edge_hit = (y_r == '0);
      default:          edge_hit = 1'b1;
    endcase
  end

  always_comb begin
    ram_wdata = nt_r;
    ram_we    = 1'b0;
    if (ctrl.op == vfcm_pkg::OP_CLEAR) begin
      ram_addr  = clr_addr;
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else if (ctrl.rd_nbr) begin
      ram_addr = nbr_addr;
    end else begin
      ram_addr = {y_r, z_r, x_r};
      // write only on change, so the dirty flag tracks real edits
      ram_we   = (ctrl.op == vfcm_pkg::OP_WR_CMP) && (rdata != nt_r);
    end
  end

  // Lowest open side goes first
  always_comb begin
    sel = vfcm_pkg::DIR_NY;
    for (int i = 5; i >= 0; i--) begin
      if (mask[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign mask_rest   = mask & ~(6'b1 << sel);
  assign out_free    = !out_valid || out_ready;
  assign emit_fire   = (ctrl.op == vfcm_pkg::OP_EMIT) && out_free && (mask != '0);
  assign status_fire = (ctrl.op == vfcm_pkg::OP_STATUS) && out_free;

  assign row_prod = 16'(rdata) * 16'(vfcm_pkg::TILE_RECIP);
  assign col_full = type_r - 8'(8'(row_r) * 8'(vfcm_pkg::TILE_DIV));

  assign lx = {1'b0, x_r} + {{CW{1'b0}}, (sel == vfcm_pkg::DIR_PX)};
  assign ly = {1'b0, y_r} + {{CW{1'b0}}, (sel == vfcm_pkg::DIR_PY)};
  assign lz = {1'b0, z_r} + {{CW{1'b0}}, (sel == vfcm_pkg::DIR_PZ)};
  assign wx = ({{5{chunk_x[11]}}, chunk_x} << EDGE_LOG2) + 17'(lx);
  assign wy = ({{5{chunk_y[11]}}, chunk_y} << EDGE_LOG2) + 17'(ly);
  assign wz = ({{5{chunk_z[11]}}, chunk_z} << EDGE_LOG2) + 17'(lz);

  assign stat.type_zero  = (rdata == '0);
  assign stat.out_free   = out_free;
  assign stat.mask_empty = (mask == '0);
  assign stat.mask_last  = (mask_rest == '0);
  assign stat.clr_done   = (clr_addr == '1);

  // Item payload and per-voxel working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r  <= CW'(vox_x);
      y_r  <= CW'(vox_y);
      z_r  <= CW'(vox_z);
      nt_r <= new_type;
    end
    if (ctrl.op == vfcm_pkg::OP_LOAD_TYPE) begin
      type_r <= rdata;
      row_r  <= row_prod[15:11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= '0;
      vcount   <= '0;
      dirty    <= 1'b0;
      chunk_x  <= '0;
      chunk_y  <= '0;
      chunk_z  <= '0;
      clr_addr <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          vfcm_pkg::REG_CHUNK_X: chunk_x <= cfg_data;
          vfcm_pkg::REG_CHUNK_Y: chunk_y <= cfg_data;
          vfcm_pkg::REG_CHUNK_Z: chunk_z <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.op == vfcm_pkg::OP_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (ram_we && (ctrl.op == vfcm_pkg::OP_WR_CMP)) begin
        dirty <= 1'b1;
      end
      if (ctrl.cap_en) begin
        mask[ctrl.cap_dir] <= edge_hit || (rdata == '0);
      end
      if (emit_fire) begin
        mask   <= mask_rest;
        vcount <= vcount + 17'd4;
      end
      if (status_fire) begin
        dirty  <= 1'b0;
        vcount <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire || status_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      record_kind <= 1'b0;
      face_dir    <= sel;
      corner_x    <= wx;
      corner_y    <= wy;
      corner_z    <= wz;
      invert      <= (sel == vfcm_pkg::DIR_PZ) || (sel == vfcm_pkg::DIR_NX) ||
                     (sel == vfcm_pkg::DIR_NY);
      tile_col    <= col_full[3:0];
      tile_row    <= row_r;
      vertex_base <= vcount;
      was_dirty   <= 1'b0;
      last        <= (mask_rest == '0);
    end else if (status_fire) begin
      record_kind <= 1'b1;
      face_dir    <= '0;
      corner_x    <= '0;
      corner_y    <= '0;
      corner_z    <= '0;
      invert      <= 1'b0;
      tile_col    <= '0;
      tile_row    <= '0;
      vertex_base <= '0;
      was_dirty   <= dirty;
      last        <= 1'b1;
    end
  end

endmodule

`default_nettype wire
